[rtl/assert_macros.svh]
// Assertion macros shared by the packed pattern decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define PPD_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked assertion on the usual clk and rst_n of the enclosing module.
`define PPD_ASSERT_CLK(lbl, prop, msg) `PPD_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

[rtl/ppd_pkg.sv]
// Shared types and constants for the packed pattern decoder.
// Depends on nothing; used by ppd_parser and packed_pattern_decoder_core.
package ppd_pkg;

  localparam int CHANNELS = 32;
  localparam int CH_W     = 5;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;

  localparam logic [7:0] NOTE_OFF      = 8'd255;
  localparam logic [7:0] VOL_MAX       = 8'd64;
  localparam logic [7:0] HDR_NOTE_ONLY = 8'h20;
  localparam logic [7:0] HDR_VOL_ONLY  = 8'h40;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic [5:0]      row;
    logic [7:0]      note;
    logic [7:0]      instrument;
    logic [7:0]      vol_pre;
    logic [7:0]      effect;
    logic [7:0]      fx_param;
    logic [2:0]      header_flags;
    logic            need_default;
    logic [7:0]      tbl_idx;
  } cell_t;

endpackage

[rtl/ppd_parser.sv]
// Byte parser of the packed pattern decoder: phase tracking, row count and the
// per-channel note, instrument and volume memories. Depends on ppd_pkg.
module ppd_parser #(
  parameter int ROWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [1:0]        kind,
  input  logic [7:0]        data_byte,
  output logic              emit,
  output ppd_pkg::cell_t    dec_cell
);

  localparam int RW = $clog2(ROWS + 1);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_NOTE   = 6'b000010,
    PH_INSTR  = 6'b000100,
    PH_VOL    = 6'b001000,
    PH_EFF    = 6'b010000,
    PH_INFO   = 6'b100000
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [7:0]                hdr_r, hdr_nxt;
  logic [7:0]                note_r, note_nxt;
  logic [7:0]                inst_r, inst_nxt;
  logic [7:0]                vol_r, vol_nxt;
  logic [7:0]                eff_r, eff_nxt;

  logic [7:0]                last_note_r [ppd_pkg::CHANNELS];
  logic [7:0]                last_inst_r [ppd_pkg::CHANNELS];
  logic [7:0]                last_vol_r  [ppd_pkg::CHANNELS];
  logic [ppd_pkg::CHANNELS-1:0] note_vld_r, inst_vld_r, vol_vld_r;

  logic [ppd_pkg::CH_W-1:0]  ch_sel;
  logic [7:0]                ln, li, lv, ln_f, li_f, lv_f;
  logic [7:0]                nv, vv, note_o, inst_o;
  logic                      row_live, done, clr_all;
  logic                      wr_note, wr_inst, wr_vol;

  assign ch_sel   = (phase_r == PH_HEADER) ? data_byte[ppd_pkg::CH_W-1:0]
                                           : hdr_r[ppd_pkg::CH_W-1:0];
  assign ln       = note_vld_r[ch_sel] ? last_note_r[ch_sel] : 8'd0;
  assign li       = inst_vld_r[ch_sel] ? last_inst_r[ch_sel] : 8'd0;
  assign lv       = vol_vld_r[ch_sel]  ? last_vol_r[ch_sel]  : 8'd0;
  assign nv       = (data_byte == ppd_pkg::NOTE_OFF) ? 8'd0 : data_byte;
  assign vv       = (data_byte > ppd_pkg::VOL_MAX) ? 8'd0 : data_byte;
  assign row_live = (row_r < RW'(ROWS));

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    hdr_nxt   = hdr_r;
    note_nxt  = note_r;
    inst_nxt  = inst_r;
    vol_nxt   = vol_r;
    eff_nxt   = eff_r;
    wr_note   = 1'b0;
    wr_inst   = 1'b0;
    wr_vol    = 1'b0;
    clr_all   = 1'b0;
    done      = 1'b0;
    if (go && kind == ppd_pkg::KIND_START) begin
      phase_nxt = PH_HEADER;
      row_nxt   = '0;
      hdr_nxt   = 8'd0;
      note_nxt  = 8'd0;
      inst_nxt  = 8'd0;
      vol_nxt   = 8'd0;
      eff_nxt   = 8'd0;
      clr_all   = 1'b1;
    end else if (go && kind == ppd_pkg::KIND_BYTE && row_live) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (data_byte == 8'd0) begin
            row_nxt = row_r + RW'(1);
          end else begin
            hdr_nxt  = data_byte;
            note_nxt = 8'd0;
            inst_nxt = 8'd0;
            vol_nxt  = 8'd0;
            eff_nxt  = 8'd0;
            if (data_byte[5]) begin
              phase_nxt = PH_NOTE;
            end else if (data_byte[6]) begin
              phase_nxt = PH_VOL;
            end else if (data_byte[7]) begin
              phase_nxt = PH_EFF;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_NOTE: begin
          note_nxt  = nv;
          wr_note   = (nv != 8'd0);
          phase_nxt = PH_INSTR;
        end
        PH_INSTR: begin
          inst_nxt = data_byte;
          wr_inst  = (data_byte != 8'd0);
          if (hdr_r[6]) begin
            phase_nxt = PH_VOL;
          end else if (hdr_r[7]) begin
            phase_nxt = PH_EFF;
          end else begin
            done = 1'b1;
          end
        end
        PH_VOL: begin
          vol_nxt = vv;
          wr_vol  = (vv != 8'd0);
          if (hdr_r[7]) begin
            phase_nxt = PH_EFF;
          end else begin
            done = 1'b1;
          end
        end
        PH_EFF: begin
          eff_nxt   = data_byte;
          phase_nxt = PH_INFO;
        end
        PH_INFO: begin
          done = 1'b1;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
      if (done) begin
        phase_nxt = PH_HEADER;
      end
    end
  end

  // The cell sees the channel memories as they stand after this beat.
  assign ln_f   = wr_note ? nv : ln;
  assign li_f   = wr_inst ? data_byte : li;
  assign lv_f   = wr_inst ? 8'd0 : (wr_vol ? vv : lv);
  assign note_o = ((hdr_nxt != ppd_pkg::HDR_VOL_ONLY) &&
                   ((hdr_nxt != ppd_pkg::HDR_NOTE_ONLY) || (note_nxt == 8'd0)))
                  ? ln_f : note_nxt;
  assign inst_o = ((hdr_nxt != ppd_pkg::HDR_VOL_ONLY) &&
                   ((hdr_nxt != ppd_pkg::HDR_NOTE_ONLY) || (inst_nxt == 8'd0)))
                  ? li_f : inst_nxt;

  assign emit = done;

  always_comb begin
    dec_cell.channel      = hdr_nxt[ppd_pkg::CH_W-1:0];
    dec_cell.row          = 6'(row_r);
    dec_cell.note         = note_o;
    dec_cell.instrument   = inst_o;
    dec_cell.vol_pre      = hdr_nxt[6] ? vol_nxt : lv_f;
    dec_cell.effect       = hdr_nxt[7] ? eff_nxt : 8'd0;
    dec_cell.fx_param     = hdr_nxt[7] ? data_byte : 8'd0;
    dec_cell.header_flags = hdr_nxt[7:5];
    dec_cell.need_default = (dec_cell.vol_pre == 8'd0) && (inst_o != 8'd0);
    dec_cell.tbl_idx      = inst_o - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      row_r   <= '0;
      hdr_r   <= 8'd0;
      note_r  <= 8'd0;
      inst_r  <= 8'd0;
      vol_r   <= 8'd0;
      eff_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      hdr_r   <= hdr_nxt;
      note_r  <= note_nxt;
      inst_r  <= inst_nxt;
      vol_r   <= vol_nxt;
      eff_r   <= eff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_vld_r <= '0;
      inst_vld_r <= '0;
      vol_vld_r  <= '0;
    end else if (clr_all) begin
      note_vld_r <= '0;
      inst_vld_r <= '0;
      vol_vld_r  <= '0;
    end else begin
      if (wr_note) begin
        note_vld_r[ch_sel] <= 1'b1;
      end
      if (wr_inst) begin
        inst_vld_r[ch_sel] <= 1'b1;
        vol_vld_r[ch_sel]  <= 1'b0;
      end
      if (wr_vol) begin
        vol_vld_r[ch_sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_note) begin
      last_note_r[ch_sel] <= nv;
    end
    if (wr_inst) begin
      last_inst_r[ch_sel] <= data_byte;
    end
    if (wr_vol) begin
      last_vol_r[ch_sel] <= vv;
    end
  end

endmodule

[rtl/ppd_vol_table.sv]
// Default instrument volume table of the packed pattern decoder, with one
// write port and one registered read port. Depends on nothing.
module ppd_vol_table #(
  parameter int INSTRUMENTS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [6:0] wr_slot,
  input  logic [7:0] wr_vol,
  input  logic       rd_en,
  input  logic [7:0] rd_idx,
  output logic [7:0] rd_vol
);

  localparam int AW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;

  logic [7:0]             mem [INSTRUMENTS];
  logic [INSTRUMENTS-1:0] vld_r;
  logic [8:0]             wr_ext, rd_ext;
  logic [AW-1:0]          wa, ra;
  logic                   wr_ok, rd_ok;
  logic [7:0]             rd_vol_r;

  assign wr_ext = {2'b00, wr_slot};
  assign rd_ext = {1'b0, rd_idx};
  assign wa     = wr_ext[AW-1:0];
  assign ra     = rd_ext[AW-1:0];
  assign wr_ok  = wr_en && (wr_ext < 9'(INSTRUMENTS));
  assign rd_ok  = (rd_ext < 9'(INSTRUMENTS));
  assign rd_vol = rd_vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wa] <= wr_vol;
    end
    if (rd_en) begin
      rd_vol_r <= (rd_ok && vld_r[ra]) ? mem[ra] : 8'd0;
    end
  end

endmodule

[rtl/packed_pattern_decoder_core.sv]
// Packed pattern decoder top level: parser, default volume table and output
// stages. Depends on ppd_pkg, ppd_parser, ppd_vol_table and assert_macros.svh.
//
// Takes one input beat every clock cycle and delivers at most one cell per
// beat; each cell passes through the table-read stage, where the default
// volume table is read, and the output register. A zero header byte ends a
// row, a new-pattern beat clears the channel memories at once (no clearing
// pass), and pattern bytes after the last row are dropped. The input stalls
// only while both the table-read stage and the output register hold cells.
`include "assert_macros.svh"

module packed_pattern_decoder_core #(
  parameter int ROWS        = 64,
  parameter int INSTRUMENTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // data_byte[7:0], instrument_slot[14:8], instrument_volume[22:15], zero pad
  input  logic [23:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // channel[4:0], row[10:5], note[18:11], instrument[26:19], volume[34:27],
  // effect[42:35], fx_param[50:43], zero pad
  output logic [55:0] out_tdata,
  // header_flags[2:0]
  output logic [2:0]  out_tuser
);

  logic           in_accept, emit, s1_move;
  ppd_pkg::cell_t dec_cell, s1_cell_r;
  logic           s1_valid_r, out_valid_r;
  logic [7:0]     tbl_vol, vol_fin;
  logic [55:0]    out_data_r;
  logic [2:0]     out_flags_r;

  assign s1_move   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_move;
  assign in_accept = in_tvalid && in_tready;

  ppd_parser #(
    .ROWS(ROWS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (in_accept),
    .kind      (in_tuser),
    .data_byte (in_tdata[7:0]),
    .emit      (emit),
    .dec_cell  (dec_cell)
  );

  ppd_vol_table #(
    .INSTRUMENTS(INSTRUMENTS)
  ) u_vol_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && (in_tuser == ppd_pkg::KIND_LOAD)),
    .wr_slot (in_tdata[14:8]),
    .wr_vol  (in_tdata[22:15]),
    .rd_en   (emit),
    .rd_idx  (dec_cell.tbl_idx),
    .rd_vol  (tbl_vol)
  );

  assign vol_fin = s1_cell_r.need_default ? tbl_vol : s1_cell_r.vol_pre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_cell_r <= dec_cell;
    end
    if (s1_move && s1_valid_r) begin
      out_data_r  <= {5'd0, s1_cell_r.fx_param, s1_cell_r.effect, vol_fin,
                      s1_cell_r.instrument, s1_cell_r.note, s1_cell_r.row,
                      s1_cell_r.channel};
      out_flags_r <= s1_cell_r.header_flags;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flags_r;

  `PPD_ASSERT_CLK(a_stall_cause,
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready), "input stalled with room left")
  `PPD_ASSERT_CLK(a_s1_hold,
    (s1_valid_r && !s1_move) |=> s1_valid_r, "stalled cell lost from the table-read stage")
  `PPD_ASSERT_CLK(a_row_range,
    out_valid_r |-> (out_data_r[10:5] < ROWS), "cell row beyond the pattern length")

endmodule

[tb/sv/packed_pattern_decoder_core_test.sv]
`timescale 1ns / 100ps
// Self-checking test of packed_pattern_decoder_core: directed and random beat streams
// are decoded by a predictor in the testbench and every delivered cell is compared.
// Depends on ppd_pkg and the decoder RTL.
module packed_pattern_decoder_core_test;

  localparam int ROWS = 64;
  localparam int INSTRUMENTS = 128;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1050;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum logic [6:0] {
    AWAIT_HEADER = 7'b0000001,
    AWAIT_NOTE   = 7'b0000010,
    AWAIT_INSTR  = 7'b0000100,
    AWAIT_VOL    = 7'b0001000,
    AWAIT_EFF    = 7'b0010000,
    AWAIT_INFO   = 7'b0100000,
    CELL_DONE    = 7'b1000000
  } parse_t;

  typedef struct packed {
    logic [4:0] channel;
    logic [5:0] row;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] fx_param;
    logic [2:0] flags;
  } decoded_cell_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = KIND_SPARE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;

  parse_t     phase;
  logic [6:0] row_cnt;
  logic [7:0] hdr_byte, cur_note, cur_instr, cur_eff, cur_vol;
  logic [7:0] last_note [ppd_pkg::CHANNELS];
  logic [7:0] last_instr [ppd_pkg::CHANNELS];
  logic [7:0] last_vol [ppd_pkg::CHANNELS];
  logic [7:0] vol_table [INSTRUMENTS];

  decoded_cell_t pending_cells[$];
  int  mismatches = 0;
  int  beats_sent = 0;
  int  cells_checked = 0;
  int  patterns_run = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  packed_pattern_decoder_core #(
    .ROWS        (ROWS),
    .INSTRUMENTS (INSTRUMENTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
    end
  endtask

  function automatic parse_t next_field(logic [7:0] h, parse_t from);
    if (from <= AWAIT_INSTR && h[5]) return (from <= AWAIT_NOTE) ? AWAIT_NOTE : AWAIT_INSTR;
    if (from <= AWAIT_VOL && h[6]) return AWAIT_VOL;
    if (h[7]) return (from <= AWAIT_EFF) ? AWAIT_EFF : AWAIT_INFO;
    return CELL_DONE;
  endfunction

  function automatic void clear_cell_regs();
    cur_note = '0;
    cur_instr = '0;
    cur_eff = '0;
    cur_vol = '0;
  endfunction

  function automatic void finish_cell(logic [7:0] info);
    decoded_cell_t c;
    logic [4:0] ch;
    logic [7:0] n, ins, v;
    int idx;
    ch = hdr_byte[4:0];
    n = cur_note;
    ins = cur_instr;
    if (hdr_byte != ppd_pkg::HDR_VOL_ONLY &&
        (hdr_byte != ppd_pkg::HDR_NOTE_ONLY || n == 0)) begin
      n = last_note[ch];
    end
    if (hdr_byte != ppd_pkg::HDR_VOL_ONLY &&
        (hdr_byte != ppd_pkg::HDR_NOTE_ONLY || ins == 0)) begin
      ins = last_instr[ch];
    end
    v = hdr_byte[6] ? cur_vol : last_vol[ch];
    if (v == 0 && ins != 0) begin
      idx = int'(ins) - 1;
      v = (idx < INSTRUMENTS) ? vol_table[idx] : 8'd0;
    end
    c.channel = ch;
    c.row = row_cnt[5:0];
    c.note = n;
    c.instrument = ins;
    c.volume = v;
    c.effect = hdr_byte[7] ? cur_eff : 8'd0;
    c.fx_param = hdr_byte[7] ? info : 8'd0;
    c.flags = hdr_byte[7:5];
    pending_cells.push_back(c);
    phase = AWAIT_HEADER;
  endfunction

  function automatic void decode_beat(logic [1:0] kind, logic [7:0] b, logic [6:0] slot,
                                      logic [7:0] vin);
    logic [4:0] ch;
    ch = hdr_byte[4:0];
    case (kind)
      ppd_pkg::KIND_LOAD: begin
        if (int'(slot) < INSTRUMENTS) vol_table[slot] = vin;
      end
      ppd_pkg::KIND_START: begin
        phase = AWAIT_HEADER;
        row_cnt = '0;
        hdr_byte = '0;
        clear_cell_regs();
        foreach (last_note[i]) begin
          last_note[i] = '0;
          last_instr[i] = '0;
          last_vol[i] = '0;
        end
      end
      ppd_pkg::KIND_BYTE: begin
        if (row_cnt < ROWS) begin
          unique case (phase)
            AWAIT_HEADER: begin
              if (b == 0) begin
                row_cnt++;
              end else begin
                hdr_byte = b;
                clear_cell_regs();
                phase = next_field(b, AWAIT_NOTE);
              end
            end
            AWAIT_NOTE: begin
              cur_note = (b == ppd_pkg::NOTE_OFF) ? 8'd0 : b;
              if (cur_note != 0) last_note[ch] = cur_note;
              phase = next_field(hdr_byte, AWAIT_INSTR);
            end
            AWAIT_INSTR: begin
              cur_instr = b;
              if (b != 0) begin
                last_instr[ch] = b;
                last_vol[ch] = '0;
              end
              phase = next_field(hdr_byte, AWAIT_VOL);
            end
            AWAIT_VOL: begin
              cur_vol = (b > ppd_pkg::VOL_MAX) ? 8'd0 : b;
              if (cur_vol != 0) last_vol[ch] = cur_vol;
              phase = next_field(hdr_byte, AWAIT_EFF);
            end
            AWAIT_EFF: begin
              cur_eff = b;
              phase = AWAIT_INFO;
            end
            AWAIT_INFO: begin
              finish_cell(b);
            end
            default: begin
              phase = AWAIT_HEADER;
            end
          endcase
          if (phase == CELL_DONE) finish_cell(8'h00);
        end
      end
      default: ;
    endcase
  endfunction

  initial begin
    phase = AWAIT_HEADER;
    row_cnt = '0;
    hdr_byte = '0;
    clear_cell_regs();
    foreach (last_note[i]) begin
      last_note[i] = '0;
      last_instr[i] = '0;
      last_vol[i] = '0;
    end
    foreach (vol_table[i]) vol_table[i] = '0;
  end

  always @(posedge clk) begin : monitor
    decoded_cell_t got, want;
    if (rst_n && in_tvalid && in_tready) begin
      decode_beat(in_tuser, in_tdata[7:0], in_tdata[14:8], in_tdata[22:15]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.channel = out_tdata[4:0];
      got.row = out_tdata[10:5];
      got.note = out_tdata[18:11];
      got.instrument = out_tdata[26:19];
      got.volume = out_tdata[34:27];
      got.effect = out_tdata[42:35];
      got.fx_param = out_tdata[50:43];
      got.flags = out_tuser;
      cells_checked++;
      if (pending_cells.size() == 0) begin
        report_mismatch("cell with nothing expected, channel", got.channel, 0);
      end else begin
        want = pending_cells.pop_front();
        if (got.channel !== want.channel) report_mismatch("channel", got.channel, want.channel);
        if (got.row !== want.row) report_mismatch("row", got.row, want.row);
        if (got.note !== want.note) report_mismatch("note", got.note, want.note);
        if (got.instrument !== want.instrument) begin
          report_mismatch("instrument", got.instrument, want.instrument);
        end
        if (got.volume !== want.volume) report_mismatch("volume", got.volume, want.volume);
        if (got.effect !== want.effect) report_mismatch("effect", got.effect, want.effect);
        if (got.fx_param !== want.fx_param) begin
          report_mismatch("effect parameter", got.fx_param, want.fx_param);
        end
        if (got.flags !== want.flags) report_mismatch("header_flags", got.flags, want.flags);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_beat(logic [1:0] kind, logic [7:0] b, logic [6:0] slot, logic [7:0] vin);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {1'b0, vin, slot, b};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(ppd_pkg::KIND_BYTE, b, 7'($urandom), 8'($urandom));
  endtask

  task automatic send_load(logic [6:0] slot, logic [7:0] vin);
    send_beat(ppd_pkg::KIND_LOAD, 8'($urandom), slot, vin);
  endtask

  task automatic send_start();
    send_beat(ppd_pkg::KIND_START, 8'($urandom), 7'($urandom), 8'($urandom));
  endtask

  task automatic send_cell(logic [7:0] hdr, logic [7:0] note, logic [7:0] instr,
                           logic [7:0] vol, logic [7:0] eff, logic [7:0] info);
    send_byte(hdr);
    if (hdr[5]) begin
      send_byte(note);
      send_byte(instr);
    end
    if (hdr[6]) send_byte(vol);
    if (hdr[7]) begin
      send_byte(eff);
      send_byte(info);
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_cells();
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  task automatic random_pattern(int rows);
    logic [7:0] hdr, note, instr, vol;
    int noise;
    repeat ($urandom_range(0, 4)) begin
      send_load(($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15)),
                8'($urandom));
    end
    send_start();
    patterns_run++;
    for (int r = 0; r < rows; r++) begin
      repeat ($urandom_range(0, 3)) begin
        noise = $urandom_range(0, 15);
        case (noise)
          0: send_beat(KIND_SPARE, 8'($urandom), 7'($urandom), 8'($urandom));
          1: send_load(7'($urandom_range(0, 15)), 8'($urandom));
          2: send_byte(8'($urandom));
          default: ;
        endcase
        case ($urandom_range(0, 9))
          0: hdr = ppd_pkg::HDR_NOTE_ONLY;
          1: hdr = ppd_pkg::HDR_VOL_ONLY;
          default: hdr = {3'($urandom), 5'($urandom)};
        endcase
        if (hdr == 0) hdr = 8'h01;
        case ($urandom_range(0, 5))
          0: note = 8'd0;
          1: note = ppd_pkg::NOTE_OFF;
          default: note = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: instr = 8'd0;
          1: instr = 8'($urandom_range(129, 255));
          default: instr = 8'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 5))
          0: vol = 8'($urandom_range(65, 255));
          1: vol = 8'd0;
          default: vol = 8'($urandom_range(1, 64));
        endcase
        send_cell(hdr, note, instr, vol, 8'($urandom), 8'($urandom));
        if (noise == 3) send_start();
      end
      send_byte(8'h00);
    end
  endtask

  task automatic test_directed_cells();
    send_load(7'd0, 8'h40);
    send_load(7'd127, 8'hFF);
    send_load(7'd5, 8'h00);
    send_start();
    send_cell(8'hFF, ppd_pkg::NOTE_OFF, 8'd128, 8'd65, 8'hFF, 8'hFF);
    send_cell(ppd_pkg::HDR_NOTE_ONLY, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_cell(ppd_pkg::HDR_NOTE_ONLY, 8'h4C, 8'd1, 8'd0, 8'd0, 8'd0);
    send_cell(ppd_pkg::HDR_VOL_ONLY, 8'd0, 8'd0, 8'd200, 8'd0, 8'd0);
    send_cell(8'h41, 8'd0, 8'd0, 8'd64, 8'd0, 8'd0);
    send_cell(8'h82, 8'd0, 8'd0, 8'd0, 8'h13, 8'h80);
    send_cell(8'h23, 8'h10, 8'd200, 8'd0, 8'd0, 8'd0);
    send_beat(KIND_SPARE, 8'h20, 7'h7F, 8'hFF);
    send_byte(8'h00);
    send_byte(8'h61);
    send_byte(8'h31);
    send_load(7'd6, 8'h22);
    send_byte(8'd7);
    send_byte(8'd0);
    send_byte(8'hE4);
    send_byte(8'h12);
    send_start();
    send_cell(8'h05, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_rows_exhausted();
    send_start();
    send_cell(8'hE9, 8'h31, 8'd1, 8'd10, 8'h01, 8'h02);
    repeat (ROWS) send_byte(8'h00);
    send_cell(8'hE9, 8'h31, 8'd1, 8'd10, 8'h01, 8'h02);
    send_byte(8'h00);
    send_start();
    send_cell(8'hE9, 8'h31, 8'd1, 8'd10, 8'h01, 8'h02);
  endtask

  task automatic test_random_patterns();
    while (beats_sent < RANDOM_BEATS) begin
      random_pattern(($urandom_range(0, 9) == 0) ? 66 : $urandom_range(1, 8));
    end
  endtask

  task automatic test_drain_pause();
    random_pattern(3);
    release_input();
    wait_for_cells();
    random_pattern(3);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (6) random_pattern($urandom_range(2, 6));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cells();
    test_rows_exhausted();
    test_random_patterns();
    test_drain_pause();
    test_steady_stream();
    release_input();
    wait_for_cells();
    repeat (8) @(posedge clk);
    if (pending_cells.size() != 0) begin
      report_mismatch("cells never delivered", pending_cells.size(), 0);
    end
    $display("Sent %0d beats over %0d random patterns, checked %0d cells.",
             beats_sent, patterns_run, cells_checked);
    $display("Covered fill rules, default volumes, row overrun, restarts and stalls.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/ppd_pkg.sv
rtl/ppd_parser.sv
rtl/ppd_vol_table.sv
rtl/packed_pattern_decoder_core.sv
tb/sv/packed_pattern_decoder_core_test.sv
